FILE: rtl/core/cubic_spline_evaluator_assert.svh
// Assertion macros for the spline evaluator checker
`ifndef CUBIC_SPLINE_EVALUATOR_ASSERT_SVH
`define CUBIC_SPLINE_EVALUATOR_ASSERT_SVH
// implication checked on every clock, off in reset
`define CSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Types and codes shared by the spline evaluator modules.
// ----------------------------------------------------------------------------
package cse_pkg;
  localparam logic [2:0] FUNC_LOAD   = 3'd0;
  localparam logic [2:0] FUNC_VALUE  = 3'd1;
  localparam logic [2:0] FUNC_DERIV1 = 3'd2;
  localparam logic [2:0] FUNC_DERIV2 = 3'd3;
  localparam logic [2:0] FUNC_DERIV3 = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD0, ST_CHK0, ST_RDN, ST_CHKN, ST_SRD, ST_SCHK,
    ST_COEF, ST_PREP, ST_MUL, ST_ACC, ST_DONE
  } state_t;

  // multiply-accumulate addend selector
  typedef enum logic [1:0] {ADD_C, ADD_B, ADD_Y, ADD_C2} addsel_t;

  typedef struct packed {
    logic    ld_query;   // capture query and clear flags
    logic    rd_first;   // read knot 0
    logic    rd_last;    // read knot n
    logic    rd_search;  // read knot j
    logic    rd_seg;     // read segment j-1
    logic    sel_outside; // latch outside result
    logic    srch_next;  // j <= j+1
    logic    prep;       // form h and starting term
    logic    mul;        // register h*t
    logic    acc;        // t <= sat(addend + product)
    addsel_t addsel;
    logic    done;       // strobe result
  } cmd_t;

  typedef struct packed {
    logic below_first;  // x <= x[0]
    logic above_last;   // x >= x[n]
    logic search_stop;  // j >= n or x <= x[j]
  } stat_t;
endpackage

FILE: rtl/core/cse_datapath.sv
// ----------------------------------------------------------------------------
// cse_datapath
// Knot and coefficient stores, search compare and shared Horner MAC.
// ----------------------------------------------------------------------------
module cse_datapath import cse_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int FRAC_BITS    = 16,
  parameter int KW           = $clog2(MAX_SEGMENTS + 2)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               ld_we,
  input  logic [KW-1:0]      ld_idx,
  input  logic [6:0]         cfg_count,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_y_value,
  input  logic signed [31:0] in_coef_linear,
  input  logic signed [31:0] in_coef_square,
  input  logic signed [31:0] in_coef_cube,
  output logic [2:0]         func_q,
  output logic signed [31:0] result_value,
  output logic               outside_range,
  output logic               saturated
);
  localparam int AW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic signed [63:0] SMAX = 64'sd2147483647;
  localparam logic signed [63:0] SMIN = -64'sd2147483648;

  logic signed [31:0] kx_mem [MAX_SEGMENTS+1];
  logic signed [31:0] ky_mem [MAX_SEGMENTS+1];
  logic signed [31:0] sb_mem [MAX_SEGMENTS];
  logic signed [31:0] sc_mem [MAX_SEGMENTS];
  logic signed [31:0] sd_mem [MAX_SEGMENTS];

  logic [AW-1:0] seg_n, j_r, kaddr;
  logic signed [31:0] kx_rd_r, ky_rd_r, b_r, c_r, d_r, x_r, t_r;
  logic [2:0] func_r;
  logic [32:0] h_r;
  logic signed [65:0] prod_r;
  logic sat_r, out_r;
  logic signed [31:0] res_r;

  // clamp segment count
  always_comb begin
    if (cfg_count == 7'd0) seg_n = AW'(1);
    else if ({25'd0, cfg_count} > 32'(MAX_SEGMENTS)) seg_n = AW'(MAX_SEGMENTS);
    else seg_n = AW'(cfg_count);
  end

  always_comb begin
    kaddr = j_r;
    if (cmd.rd_first) kaddr = '0;
    else if (cmd.rd_last) kaddr = seg_n;
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      kx_mem[ld_idx[AW-1:0]] <= in_x_value;
      ky_mem[ld_idx[AW-1:0]] <= in_y_value;
      if (ld_idx != '0) begin
        sb_mem[SW'(ld_idx - KW'(1))] <= in_coef_linear;
        sc_mem[SW'(ld_idx - KW'(1))] <= in_coef_square;
        sd_mem[SW'(ld_idx - KW'(1))] <= in_coef_cube;
      end
    end
    if (cmd.rd_first || cmd.rd_last || cmd.rd_search || cmd.rd_seg) begin
      kx_rd_r <= kx_mem[cmd.rd_seg ? j_r - AW'(1) : kaddr];
      ky_rd_r <= ky_mem[cmd.rd_seg ? j_r - AW'(1) : kaddr];
    end
    if (cmd.rd_seg) begin
      b_r <= sb_mem[SW'(j_r - AW'(1))];
      c_r <= sc_mem[SW'(j_r - AW'(1))];
      d_r <= sd_mem[SW'(j_r - AW'(1))];
    end
  end

  assign stat.below_first = (x_r <= kx_rd_r);
  assign stat.above_last  = (x_r >= kx_rd_r);
  assign stat.search_stop = (j_r >= seg_n) || (x_r <= kx_rd_r);

  logic signed [63:0] d3, d6, addend, sum;
  logic signed [65:0] prod_nxt;

  always_comb begin
    d3 = 64'(d_r) * 64'sd3;
    d6 = 64'(d_r) * 64'sd6;
    prod_nxt = $signed({1'b0, h_r}) * 66'(t_r);
    case (cmd.addsel)
      ADD_C:   addend = 64'(c_r);
      ADD_B:   addend = 64'(b_r);
      ADD_Y:   addend = 64'(ky_rd_r);
      default: addend = 64'(c_r) * 64'sd2;
    endcase
    // scaled product stays within 48 bits, so the sum is exact
    sum = addend + 64'(prod_r >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= '0;
      func_r <= '0;
    end else begin
      if (cmd.ld_query) begin
        func_r <= in_func;
        j_r <= AW'(1);
      end
      if (cmd.srch_next) j_r <= j_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_query) begin
      x_r <= in_x_value;
      sat_r <= 1'b0;
      out_r <= 1'b0;
    end
    if (cmd.sel_outside) begin
      out_r <= 1'b1;
      res_r <= (func_r == FUNC_VALUE) ? ky_rd_r : '0;
    end
    if (cmd.prep) begin
      h_r <= 33'($signed({x_r[31], x_r}) - $signed({kx_rd_r[31], kx_rd_r}));
      unique case (func_r)
        FUNC_VALUE: t_r <= d_r;
        FUNC_DERIV1: begin
          t_r <= (d3 > SMAX) ? SMAX[31:0] : (d3 < SMIN) ? SMIN[31:0] : d3[31:0];
          if (d3 > SMAX || d3 < SMIN) sat_r <= 1'b1;
        end
        default: begin
          t_r <= (d6 > SMAX) ? SMAX[31:0] : (d6 < SMIN) ? SMIN[31:0] : d6[31:0];
          res_r <= (d6 > SMAX) ? SMAX[31:0] : (d6 < SMIN) ? SMIN[31:0] : d6[31:0];
          if (d6 > SMAX || d6 < SMIN) sat_r <= 1'b1;
        end
      endcase
    end
    if (cmd.mul) prod_r <= prod_nxt;
    if (cmd.acc) begin
      t_r <= (sum > SMAX) ? SMAX[31:0] : (sum < SMIN) ? SMIN[31:0] : sum[31:0];
      res_r <= (sum > SMAX) ? SMAX[31:0] : (sum < SMIN) ? SMIN[31:0] : sum[31:0];
      if (sum > SMAX || sum < SMIN) sat_r <= 1'b1;
    end
  end

  assign func_q = func_r;
  assign result_value = res_r;
  assign outside_range = out_r;
  assign saturated = sat_r;
endmodule

FILE: rtl/core/cse_controller.sv
// ----------------------------------------------------------------------------
// cse_controller
// Sequencer: outside tests, linear knot search, Horner steps.
// ----------------------------------------------------------------------------
module cse_controller import cse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [2:0] func_q,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy
);
  state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    cmd = '0;
    cmd.addsel = ADD_C;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        cmd.ld_query = go;
        if (go) state_nxt = ST_RD0;
      end
      ST_RD0: begin cmd.rd_first = 1'b1; state_nxt = ST_CHK0; end
      ST_CHK0: begin
        if (stat.below_first) begin
          cmd.sel_outside = 1'b1; state_nxt = ST_DONE;
        end else state_nxt = ST_RDN;
      end
      ST_RDN: begin cmd.rd_last = 1'b1; state_nxt = ST_CHKN; end
      ST_CHKN: begin
        if (stat.above_last) begin
          cmd.sel_outside = 1'b1; state_nxt = ST_DONE;
        end else state_nxt = ST_SRD;
      end
      ST_SRD: begin cmd.rd_search = 1'b1; state_nxt = ST_SCHK; end
      ST_SCHK: begin
        if (stat.search_stop) state_nxt = ST_COEF;
        else begin cmd.srch_next = 1'b1; state_nxt = ST_SRD; end
      end
      ST_COEF: begin cmd.rd_seg = 1'b1; state_nxt = ST_PREP; end
      ST_PREP: begin
        cmd.prep = 1'b1;
        step_nxt = '0;
        state_nxt = (func_q == FUNC_DERIV3) ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin cmd.mul = 1'b1; state_nxt = ST_ACC; end
      ST_ACC: begin
        cmd.acc = 1'b1;
        step_nxt = step_r + 2'd1;
        state_nxt = ST_MUL;
        case (func_q)
          FUNC_VALUE: begin
            cmd.addsel = (step_r == 2'd0) ? ADD_C : (step_r == 2'd1) ? ADD_B : ADD_Y;
            if (step_r == 2'd2) state_nxt = ST_DONE;
          end
          FUNC_DERIV1: begin
            cmd.addsel = (step_r == 2'd0) ? ADD_C2 : ADD_B;
            if (step_r == 2'd1) state_nxt = ST_DONE;
          end
          default: begin
            cmd.addsel = ADD_C2;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin cmd.done = 1'b1; state_nxt = ST_IDLE; end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/cubic_spline_evaluator.sv
// ----------------------------------------------------------------------------
// cubic_spline_evaluator
// Piecewise cubic spline value and derivative evaluation, Q16.16.
//
//  channel  | handshake          | payload
//  in_      | start & !busy      | func, knot_index, x, y, b, c, d
//  out_     | out_valid (1 cyc)  | result_value, outside_range, saturated
//  cfg_     | cfg_we             | cfg_data (segment_count)
//
// Loads do not make the block busy. For a query, a linear scan reads
// the knots one at a time from the knot store, then a shared multiplier
// runs up to three Horner steps, each a multiply and an accumulate.
// Reset is synchronous; store contents are undefined until loaded.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module cubic_spline_evaluator import cse_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_func,
  input  logic [6:0]         in_knot_index,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_y_value,
  input  logic signed [31:0] in_coef_linear,
  input  logic signed [31:0] in_coef_square,
  input  logic signed [31:0] in_coef_cube,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic               out_outside_range,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data
);
  localparam int KW = $clog2(MAX_SEGMENTS + 2);
  logic [6:0] count_r;
  cmd_t cmd;
  stat_t stat;
  logic [2:0] func_q;
  logic accept, is_query, ld_we, busy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= 7'd1;
    else if (cfg_we) count_r <= cfg_data;
  end

  assign accept = start && !busy;
  assign is_query = (in_func == FUNC_VALUE) || (in_func == FUNC_DERIV1) ||
                    (in_func == FUNC_DERIV2) || (in_func == FUNC_DERIV3);
  assign ld_we = accept && (in_func == FUNC_LOAD) &&
                 ({25'd0, in_knot_index} <= 32'(MAX_SEGMENTS));

  cse_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .ld_we, .ld_idx(KW'(in_knot_index)),
    .cfg_count(count_r), .in_func, .in_x_value, .in_y_value,
    .in_coef_linear, .in_coef_square, .in_coef_cube, .func_q,
    .result_value(out_result_value), .outside_range(out_outside_range),
    .saturated(out_saturated)
  );

  cse_controller u_ctl (
    .clk, .rst_n, .go(accept && is_query), .func_q, .stat, .cmd, .busy(busy_c)
  );

  assign busy = busy_c;
  assign out_valid = cmd.done;
endmodule

FILE: rtl/core/cse_checker.sv
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks on the spline evaluator.
// ----------------------------------------------------------------------------
`include "cubic_spline_evaluator_assert.svh"
module cse_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_saturated,
  input logic out_outside_range
);
  `CSE_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy, "result outside a request")
  `CSE_ASSERT_NEXT(a_valid_once, clk, rst_n, out_valid, !out_valid, "double result")
  `CSE_ASSERT_NEXT(a_free_after, clk, rst_n, out_valid, !busy, "busy after result")
  `CSE_ASSERT_IMP(a_out_nosat, clk, rst_n, out_valid && out_outside_range, !out_saturated,
    "outside result saturated")
endmodule

bind cubic_spline_evaluator cse_checker u_chk (
  .clk, .rst_n, .busy, .out_valid, .out_saturated, .out_outside_range
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Spline evaluator testbench
// Loads knot tables and drives value and derivative queries with random
// bursts and gaps, for several segment counts. A scoreboard predicts each
// result from its own copy of the tables and checks every result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import cse_pkg::*;

typedef struct {
  logic signed [31:0] value;
  logic               outside;
  logic               sat;
} spline_result_t;

class spline_scoreboard;
  longint         abscissa[65];
  longint         ordinate[65];
  longint         lin[64];
  longint         sq[64];
  longint         cub[64];
  int unsigned    seg_count = 1;
  spline_result_t expected_q[$];
  int             errors = 0;

  function longint clamp32(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function longint scale_mul(longint h, longint q);
    return (h * q) >>> 16;
  endfunction

  function void set_count(logic [6:0] v);
    seg_count = v;
  endfunction

  function void note_request(logic [2:0] func, logic [6:0] idx, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] b,
                             logic signed [31:0] c, logic signed [31:0] d);
    spline_result_t r;
    int unsigned    n;
    int unsigned    j;
    longint         xs;
    longint         h;
    longint         t;
    longint         res;
    bit             f;
    xs = x;
    f = 0;
    res = 0;
    if (func == FUNC_LOAD) begin
      if (idx <= 64) begin
        abscissa[idx] = x;
        ordinate[idx] = y;
        if (idx >= 1) begin
          lin[idx-1] = b;
          sq[idx-1]  = c;
          cub[idx-1] = d;
        end
      end
      return;
    end
    if (func > FUNC_DERIV3) return;
    n = seg_count;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    r.outside = 0;
    if (xs <= abscissa[0]) begin
      r.outside = 1;
      if (func == FUNC_VALUE) res = ordinate[0];
    end else if (xs >= abscissa[n]) begin
      r.outside = 1;
      if (func == FUNC_VALUE) res = ordinate[n];
    end else begin
      j = 1;
      while (j < n && xs > abscissa[j]) j++;
      h = xs - abscissa[j-1];
      case (func)
        FUNC_VALUE: begin
          t = clamp32(sq[j-1] + scale_mul(h, cub[j-1]), f);
          t = clamp32(lin[j-1] + scale_mul(h, t), f);
          res = clamp32(ordinate[j-1] + scale_mul(h, t), f);
        end
        FUNC_DERIV1: begin
          t = clamp32(3 * cub[j-1], f);
          t = clamp32(2 * sq[j-1] + scale_mul(h, t), f);
          res = clamp32(lin[j-1] + scale_mul(h, t), f);
        end
        FUNC_DERIV2: begin
          t = clamp32(6 * cub[j-1], f);
          res = clamp32(2 * sq[j-1] + scale_mul(h, t), f);
        end
        default: res = clamp32(6 * cub[j-1], f);
      endcase
    end
    r.value = res[31:0];
    r.sat = f;
    expected_q.push_back(r);
  endfunction

  function void check_result(logic signed [31:0] v, logic o, logic s);
    spline_result_t e;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result value=%h outside=%b sat=%b", $time, v, o, s);
      return;
    end
    e = expected_q.pop_front();
    if (v !== e.value || o !== e.outside || s !== e.sat) begin
      errors++;
      $display("%0t: mismatch expected value=%h outside=%b sat=%b, got value=%h outside=%b sat=%b",
               $time, e.value, e.outside, e.sat, v, o, s);
    end
  endfunction
endclass

module testbench;
  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic [2:0]         in_func = '0;
  logic [6:0]         in_knot_index = '0;
  logic signed [31:0] in_x_value = '0;
  logic signed [31:0] in_y_value = '0;
  logic signed [31:0] in_coef_linear = '0;
  logic signed [31:0] in_coef_square = '0;
  logic signed [31:0] in_coef_cube = '0;
  logic               out_valid;
  logic signed [31:0] out_result_value;
  logic               out_outside_range;
  logic               out_saturated;
  logic               cfg_we = 0;
  logic [6:0]         cfg_data = '0;

  spline_scoreboard sb = new();
  longint           knot_x[65];
  int               burst_left = 0;
  int unsigned      active_segs = 1;

  cubic_spline_evaluator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_knot_index(in_knot_index), .in_x_value(in_x_value),
    .in_y_value(in_y_value), .in_coef_linear(in_coef_linear),
    .in_coef_square(in_coef_square), .in_coef_cube(in_coef_cube),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_outside_range(out_outside_range), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_result_value, out_outside_range, out_saturated);
      if (start && !busy)
        sb.note_request(in_func, in_knot_index, in_x_value, in_y_value,
                        in_coef_linear, in_coef_square, in_coef_cube);
      if (cfg_we) sb.set_count(cfg_data);
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  task send_request(logic [2:0] f, logic [6:0] idx, longint x, longint y,
                    longint b, longint c, longint d);
    if (burst_left == 0) begin
      start = 0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 20) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start = 1;
    in_func = f;
    in_knot_index = idx;
    in_x_value = x[31:0];
    in_y_value = y[31:0];
    in_coef_linear = b[31:0];
    in_coef_square = c[31:0];
    in_coef_cube = d[31:0];
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 0;
  endtask

  task wait_idle();
    start = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (160) @(negedge clk);
  endtask

  task write_count(logic [6:0] v);
    wait_idle();
    cfg_we = 1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    active_segs = (v == 0) ? 1 : (v > 64) ? 64 : v;
  endtask

  function longint rand_coef(bit wide);
    if (wide) return longint'(signed'($urandom()));
    return longint'($urandom_range(0, 2097152)) - 1048576;
  endfunction

  // all 65 knots are always written, so no query reads an empty entry
  task load_table(bit sorted, bit wide);
    longint x;
    x = -64'sd2147483648 + $urandom_range(0, 67108864);
    for (int k = 0; k <= 64; k++) begin
      if (!sorted) x = longint'(signed'($urandom()));
      else if (k > 0) x += $urandom_range(1, $urandom_range(0, 1) ? 1000000 : 60000000);
      knot_x[k] = x;
      send_request(FUNC_LOAD, 7'(k), x, rand_coef(wide), rand_coef(wide), rand_coef(wide),
                   rand_coef(wide));
    end
  endtask

  function longint pick_query();
    int unsigned j;
    longint      gap;
    j = $urandom_range(1, active_segs);
    gap = knot_x[j] - knot_x[j-1];
    case ($urandom_range(0, 9))
      0: return knot_x[$urandom_range(0, active_segs)];
      1: return longint'(signed'($urandom()));
      default: return (gap > 0) ? knot_x[j-1] + $urandom_range(1, gap) : knot_x[j];
    endcase
  endfunction

  task random_queries(int count);
    logic [2:0] f;
    for (int i = 0; i < count; i++) begin
      f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(1, 4));
      if ($urandom_range(0, 29) == 0)
        send_request(FUNC_LOAD, 7'($urandom_range(65, 127)), longint'($urandom()),
                     longint'($urandom()), longint'($urandom()), longint'($urandom()),
                     longint'($urandom()));
      else
        send_request(f, 7'($urandom()), pick_query(), longint'($urandom()),
                     longint'($urandom()), longint'($urandom()), longint'($urandom()));
    end
  endtask

  initial begin
    logic [6:0] counts[6] = '{7'd0, 7'd2, 7'd64, 7'd127, 7'd1, 7'd7};
    repeat (4) @(negedge clk);
    rst_n = 1;

    write_count(4);
    load_table(1, 1);
    send_request(FUNC_VALUE, 7'd0, -64'sd2147483648, 0, 0, 0, 0);
    send_request(FUNC_DERIV1, 7'd0, -64'sd2147483648, 0, 0, 0, 0);
    send_request(FUNC_VALUE, 7'd0, 64'sd2147483647, 0, 0, 0, 0);
    send_request(FUNC_DERIV3, 7'd0, 64'sd2147483647, 0, 0, 0, 0);
    send_request(FUNC_VALUE, 7'd0, knot_x[0], 0, 0, 0, 0);
    send_request(FUNC_DERIV2, 7'd0, knot_x[4], 0, 0, 0, 0);
    send_request(FUNC_LOAD, 7'd127, 0, 0, 0, 0, 0);
    send_request(FUNC_LOAD, 7'd100, 0, 0, 0, 0, 0);
    send_request(FUNC_LOAD, 7'd2, knot_x[2], 64'sd2147483647, 64'sd2147483647,
                 64'sd2147483647, 64'sd2147483647);
    send_request(FUNC_LOAD, 7'd3, knot_x[3], -64'sd2147483648, -64'sd2147483648,
                 -64'sd2147483648, -64'sd2147483648);
    for (int f = FUNC_VALUE; f <= 7; f++) begin
      send_request(3'(f), 7'd0, knot_x[1] + 1, 0, 0, 0, 0);
      send_request(3'(f), 7'd0, knot_x[3] - 1, 0, 0, 0, 0);
    end
    send_request(FUNC_VALUE, 7'd0, knot_x[2], 0, 0, 0, 0);

    foreach (counts[p]) begin
      write_count(counts[p]);
      load_table(p != 3, 1'(p % 2));
      random_queries(30);
    end

    wait_idle();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/cse_pkg.sv
rtl/core/cse_datapath.sv
rtl/core/cse_controller.sv
rtl/core/cubic_spline_evaluator.sv
rtl/core/cse_checker.sv
tb/testbench.sv
